@@ design/log_binned_table_interpolator_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LOG_BINNED_TABLE_INTERPOLATOR_DEFINES_SVH
`define LOG_BINNED_TABLE_INTERPOLATOR_DEFINES_SVH

// Check that a condition implies another at the same clock edge.
`define LBTI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another a fixed number of cycles later.
`define LBTI_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ design/lbti_pkg.sv @@
`default_nettype none
package lbti_pkg;

    localparam int TABLE_DEPTH   = 1024;
    localparam int LOG_FRAC_BITS = 26;

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int T_W       = 48;
    localparam int V_W       = 32;
    localparam int IDX_W     = 10;
    localparam int NCNT_W    = 11;
    localparam int BASE_W    = 32;
    localparam int SCALE_W   = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    // log2 result: signed integer part of 7 bits, then the fraction
    localparam int LOG_INT_W = 7;
    localparam int LOG_W     = LOG_INT_W + LOG_FRAC_BITS;
    localparam int D_W       = ((LOG_W > BASE_W) ? LOG_W : BASE_W) + 1;
    localparam int DMAG_W    = D_W - 1;
    localparam int DLO_W     = 16;
    localparam int DHI_W     = DMAG_W - DLO_W;
    localparam int PROD_W    = DMAG_W + SCALE_W;
    localparam int BIN_SHIFT = LOG_FRAC_BITS + 24;
    localparam int M_W       = 32;

    localparam int DIV_STEPS = 31;
    localparam int Q_W       = DIV_STEPS + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // edges from accepting a lookup to sampling its done strobe
    localparam int RESULT_LATENCY = LOG_FRAC_BITS + DIV_STEPS + 12;

    localparam logic [NCNT_W-1:0] NODE_COUNT_RST = NCNT_W'(501);
    localparam logic [BASE_W-1:0] LOG2_MIN_RST   = 32'hCAD96298;
    localparam logic [SCALE_W-1:0] BIN_SCALE_RST = 32'd360745376;
    localparam logic [T_W-1:0]    EDGE_MIN_RST   = 48'd27487791;
    localparam logic [T_W-1:0]    EDGE_MAX_RST   = 48'd274877906944000;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MAX   = 3'd4;

    typedef enum logic [1:0] {
        RANGE_INSIDE = 2'd0,
        RANGE_LOW    = 2'd1,
        RANGE_HIGH   = 2'd2
    } range_t;

    typedef struct packed {
        logic [CNT_W-1:0]   n;
        logic [BASE_W-1:0]  log2_min;
        logic [SCALE_W-1:0] scale;
        logic [T_W-1:0]     edge_min;
        logic [T_W-1:0]     edge_max;
    } cfg_t;

    typedef struct packed {
        logic              is_load;
        range_t            flag;
        logic [ADDR_W-1:0] addr;
        logic [T_W-1:0]    t;
        logic [V_W-1:0]    vel;
    } qitem_t;

endpackage
`default_nettype wire

@@ design/lbti_ram.sv @@
`default_nettype none
module lbti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule
`default_nettype wire

@@ design/lbti_front.sv @@
`default_nettype none
module lbti_front
    import lbti_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic             action,
    input  wire logic [T_W-1:0]   t_ratio,
    input  wire logic [IDX_W-1:0] entry_index,
    input  wire logic [T_W-1:0]   entry_energy,
    input  wire logic [V_W-1:0]   entry_velocity,
    input  wire cfg_t             cfg,
    output logic                  push,
    output qitem_t                push_item
);

    function automatic logic [4:0] lod16(input logic [15:0] x);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (x[i])
            begin
                r = {1'b1, 4'(i)};
            end
        end
        return r;
    endfunction

    // accept stage: classify against the edges
    logic   s0_valid_reg;
    logic   s0_valid_next;
    qitem_t s0_item_reg;
    qitem_t s0_item_next;

    always_comb
    begin
        s0_item_next.is_load = (action == ACT_LOAD);
        s0_item_next.t       = (action == ACT_LOAD) ? entry_energy : t_ratio;
        s0_item_next.vel     = entry_velocity;
        s0_item_next.flag    = RANGE_INSIDE;
        s0_item_next.addr    = '0;
        if (action == ACT_LOAD)
        begin
            s0_item_next.addr = ADDR_W'(entry_index);
        end
        else if (t_ratio <= cfg.edge_min)
        begin
            s0_item_next.flag = RANGE_LOW;
        end
        else if (t_ratio >= cfg.edge_max)
        begin
            s0_item_next.flag = RANGE_HIGH;
            s0_item_next.addr = ADDR_W'(cfg.n - CNT_W'(1));
        end
        // drop loads beyond the table
        s0_valid_next = accept &&
            ((action == ACT_LOOKUP) || (32'(entry_index) < 32'(TABLE_DEPTH)));
    end

    // leading one per 16-bit chunk
    logic             s1_valid_reg;
    qitem_t           s1_item_reg;
    logic [2:0][4:0]  s1_lod_reg;

    // squaring pipeline, stage 0 holds the normalized mantissa
    logic                     sq_valid_reg [LOG_FRAC_BITS+1];
    qitem_t                   sq_item_reg  [LOG_FRAC_BITS+1];
    logic [5:0]               sq_p_reg     [LOG_FRAC_BITS+1];
    logic [M_W-1:0]           sq_m_reg     [LOG_FRAC_BITS+1];
    logic [LOG_FRAC_BITS-1:0] sq_frac_reg  [LOG_FRAC_BITS+1];

    logic [5:0]  p_next;
    logic [63:0] wide;
    logic [63:0] m_wide;

    always_comb
    begin
        if (s1_lod_reg[2][4])
        begin
            p_next = {2'b10, s1_lod_reg[2][3:0]};
        end
        else if (s1_lod_reg[1][4])
        begin
            p_next = {2'b01, s1_lod_reg[1][3:0]};
        end
        else
        begin
            p_next = {2'b00, s1_lod_reg[0][3:0]};
        end
        wide = {16'b0, s1_item_reg.t};
        if (p_next >= 6'd31)
        begin
            m_wide = wide >> (p_next - 6'd31);
        end
        else
        begin
            m_wide = wide << (6'd31 - p_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
        end
        else
        begin
            s0_valid_reg    <= s0_valid_next;
            s1_valid_reg    <= s0_valid_reg;
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg    <= s0_item_next;
        s1_item_reg    <= s0_item_reg;
        s1_lod_reg[0]  <= lod16(s0_item_reg.t[15:0]);
        s1_lod_reg[1]  <= lod16(s0_item_reg.t[31:16]);
        s1_lod_reg[2]  <= lod16(s0_item_reg.t[47:32]);
        sq_item_reg[0] <= s1_item_reg;
        sq_p_reg[0]    <= p_next;
        sq_m_reg[0]    <= m_wide[M_W-1:0];
        sq_frac_reg[0] <= '0;
    end

    for (genvar i = 0; i < LOG_FRAC_BITS; i++)
    begin : g_sq
        logic [63:0]              prod;
        logic [M_W:0]             sq;
        logic [M_W-1:0]           m_next;
        logic [LOG_FRAC_BITS-1:0] frac_next;

        always_comb
        begin
            prod      = 64'(sq_m_reg[i]) * 64'(sq_m_reg[i]);
            sq        = prod[63:31];
            frac_next = sq_frac_reg[i];
            frac_next[LOG_FRAC_BITS-1-i] = sq[M_W];
            // halve when the square reached two
            m_next    = sq[M_W] ? sq[M_W:1] : sq[M_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[i+1] <= 1'b0;
            end
            else
            begin
                sq_valid_reg[i+1] <= sq_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_item_reg[i+1] <= sq_item_reg[i];
            sq_p_reg[i+1]    <= sq_p_reg[i];
            sq_m_reg[i+1]    <= m_next;
            sq_frac_reg[i+1] <= frac_next;
        end
    end

    // offset from the table base
    logic                      d_valid_reg;
    qitem_t                    d_item_reg;
    logic                      d_pos_reg;
    logic [DMAG_W-1:0]         d_mag_reg;
    logic [LOG_INT_W-1:0]      log_int;
    logic [LOG_W-1:0]          log_val;
    logic signed [D_W-1:0]     d_next;

    always_comb
    begin
        log_int = LOG_INT_W'({1'b0, sq_p_reg[LOG_FRAC_BITS]}) - LOG_INT_W'(38);
        log_val = {log_int, sq_frac_reg[LOG_FRAC_BITS]};
        d_next  = D_W'($signed(log_val)) - D_W'($signed(cfg.log2_min));
    end

    // partial products of offset and scale
    logic                        pp_valid_reg;
    qitem_t                      pp_item_reg;
    logic                        pp_pos_reg;
    logic [DHI_W+SCALE_W-1:0]    pp_hi_reg;
    logic [DLO_W+SCALE_W-1:0]    pp_lo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg  <= 1'b0;
            pp_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg  <= sq_valid_reg[LOG_FRAC_BITS];
            pp_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_item_reg  <= sq_item_reg[LOG_FRAC_BITS];
        d_pos_reg   <= !d_next[D_W-1] && (d_next != '0);
        d_mag_reg   <= d_next[DMAG_W-1:0];
        pp_item_reg <= d_item_reg;
        pp_pos_reg  <= d_pos_reg;
        pp_hi_reg   <= {{SCALE_W{1'b0}}, d_mag_reg[DMAG_W-1:DLO_W]} *
                       {{DHI_W{1'b0}}, cfg.scale};
        pp_lo_reg   <= {{SCALE_W{1'b0}}, d_mag_reg[DLO_W-1:0]} *
                       {{DLO_W{1'b0}}, cfg.scale};
    end

    logic [PROD_W-1:0] total;
    logic [PROD_W-1:0] bin_raw;
    logic [CNT_W-1:0]  bin_lim;
    logic [PROD_W-1:0] bin_sel;

    always_comb
    begin
        total   = (PROD_W'(pp_hi_reg) << DLO_W) + PROD_W'(pp_lo_reg);
        bin_raw = total >> BIN_SHIFT;
        bin_lim = cfg.n - CNT_W'(2);
        if (!pp_pos_reg)
        begin
            bin_sel = '0;
        end
        else if (bin_raw > PROD_W'(bin_lim))
        begin
            bin_sel = PROD_W'(bin_lim);
        end
        else
        begin
            bin_sel = bin_raw;
        end
        push      = pp_valid_reg;
        push_item = pp_item_reg;
        if (!pp_item_reg.is_load && (pp_item_reg.flag == RANGE_INSIDE))
        begin
            push_item.addr = bin_sel[ADDR_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ design/lbti_queue.sv @@
`default_nettype none
module lbti_queue
    import lbti_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire qitem_t push_item,
    input  wire logic   pop,
    output logic        full,
    output logic        head_valid,
    output qitem_t      head
);

    qitem_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (FIFO_AW+1)'(1);
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - (FIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ design/lbti_back.sv @@
`default_nettype none
module lbti_back
    import lbti_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  wire qitem_t head,
    output logic        pop,
    output logic        done,
    output logic [V_W-1:0]   velocity,
    output logic [IDX_W-1:0] bin_index,
    output logic [1:0]       range_flag
);

    typedef struct packed {
        range_t            flag;
        logic [ADDR_W-1:0] bin;
        logic              use_v0;
        logic [V_W-1:0]    v0;
        logic [V_W-1:0]    absdv;
        logic              neg;
        logic [T_W-1:0]    span;
    } pay_t;

    assign pop = head_valid;

    // table access stage: loads write here, lookups read
    logic   b0_valid_reg;
    qitem_t b0_item_reg;
    logic [T_W-1:0] e0;
    logic [T_W-1:0] e1;
    logic [V_W-1:0] v0;
    logic [V_W-1:0] v1;
    logic           wen;

    assign wen = b0_valid_reg && b0_item_reg.is_load;

    lbti_ram #(.WIDTH(T_W), .DEPTH(TABLE_DEPTH)) u_energy_ram (
        .clk     (clk),
        .we      (wen),
        .waddr   (b0_item_reg.addr),
        .wdata   (b0_item_reg.t),
        .raddr_a (b0_item_reg.addr),
        .raddr_b (b0_item_reg.addr + ADDR_W'(1)),
        .rdata_a (e0),
        .rdata_b (e1)
    );

    lbti_ram #(.WIDTH(V_W), .DEPTH(TABLE_DEPTH)) u_velocity_ram (
        .clk     (clk),
        .we      (wen),
        .waddr   (b0_item_reg.addr),
        .wdata   (b0_item_reg.vel),
        .raddr_a (b0_item_reg.addr),
        .raddr_b (b0_item_reg.addr + ADDR_W'(1)),
        .rdata_a (v0),
        .rdata_b (v1)
    );

    logic              b1_valid_reg;
    range_t            b1_flag_reg;
    logic [ADDR_W-1:0] b1_bin_reg;
    logic [T_W-1:0]    b1_t_reg;

    // node differences
    logic [T_W:0]   span_w;
    logic           b2_valid_next;
    pay_t           b2_pay_next;
    logic [T_W-1:0] b2_dx_next;

    always_comb
    begin
        span_w                = {1'b0, e1} - {1'b0, e0};
        b2_valid_next         = b1_valid_reg;
        b2_pay_next.flag      = b1_flag_reg;
        b2_pay_next.bin       = b1_bin_reg;
        b2_pay_next.use_v0    = span_w[T_W] || (span_w == '0) ||
                                (b1_flag_reg != RANGE_INSIDE);
        b2_pay_next.v0        = v0;
        b2_pay_next.neg       = (v1 < v0);
        b2_pay_next.absdv     = (v1 < v0) ? (v0 - v1) : (v1 - v0);
        b2_pay_next.span      = span_w[T_W-1:0];
        b2_dx_next            = (b1_t_reg > e0) ? (b1_t_reg - e0) : '0;
    end

    logic           b2_valid_reg;
    pay_t           b2_pay_reg;
    logic [T_W-1:0] b2_dx_reg;

    // divider stages: remainder and quotient bits of dx / span
    logic           dv_valid_reg [DIV_STEPS+1];
    pay_t           dv_pay_reg   [DIV_STEPS+1];
    logic [T_W-1:0] dv_r_reg     [DIV_STEPS+1];
    logic [Q_W-1:0] dv_q_reg     [DIV_STEPS+1];

    logic first_ge;
    assign first_ge = (b2_dx_reg >= b2_pay_reg.span);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg    <= 1'b0;
            b1_valid_reg    <= 1'b0;
            b2_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else
        begin
            b0_valid_reg    <= head_valid;
            b1_valid_reg    <= b0_valid_reg && !b0_item_reg.is_load;
            b2_valid_reg    <= b2_valid_next;
            dv_valid_reg[0] <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b0_item_reg   <= head;
        b1_flag_reg   <= b0_item_reg.flag;
        b1_bin_reg    <= b0_item_reg.addr;
        b1_t_reg      <= b0_item_reg.t;
        b2_pay_reg    <= b2_pay_next;
        b2_dx_reg     <= b2_dx_next;
        dv_pay_reg[0] <= b2_pay_reg;
        // hold dx to span: that case leaves a zero remainder
        dv_r_reg[0]   <= first_ge ? '0 : b2_dx_reg;
        dv_q_reg[0]   <= Q_W'(first_ge);
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [T_W:0] r2;
        logic [T_W:0] diff;
        logic         ge;

        always_comb
        begin
            r2   = {dv_r_reg[j], 1'b0};
            diff = r2 - {1'b0, dv_pay_reg[j].span};
            ge   = (r2 >= {1'b0, dv_pay_reg[j].span});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_pay_reg[j+1] <= dv_pay_reg[j];
            dv_r_reg[j+1]   <= ge ? diff[T_W-1:0] : r2[T_W-1:0];
            dv_q_reg[j+1]   <= {dv_q_reg[j][Q_W-2:0], ge};
        end
    end

    logic        mul_valid_reg;
    pay_t        mul_pay_reg;
    logic [63:0] mul_prod_reg;

    logic [V_W-1:0] mag;
    logic [V_W-1:0] vel_next;

    always_comb
    begin
        mag = mul_prod_reg[V_W+DIV_STEPS-1:DIV_STEPS];
        if (mul_pay_reg.use_v0)
        begin
            vel_next = mul_pay_reg.v0;
        end
        else if (mul_pay_reg.neg)
        begin
            vel_next = mul_pay_reg.v0 - mag;
        end
        else
        begin
            vel_next = mul_pay_reg.v0 + mag;
        end
    end

    logic              done_reg;
    logic [V_W-1:0]    velocity_reg;
    logic [ADDR_W-1:0] bin_reg;
    range_t            flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= dv_valid_reg[DIV_STEPS];
            done_reg      <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_pay_reg  <= dv_pay_reg[DIV_STEPS];
        mul_prod_reg <= 64'(dv_pay_reg[DIV_STEPS].absdv) * 64'(dv_q_reg[DIV_STEPS]);
        velocity_reg <= vel_next;
        bin_reg      <= mul_pay_reg.bin;
        flag_reg     <= mul_pay_reg.flag;
    end

    assign done       = done_reg;
    assign velocity   = velocity_reg;
    assign bin_index  = IDX_W'(bin_reg);
    assign range_flag = flag_reg;

endmodule
`default_nettype wire

@@ design/log_binned_table_interpolator.sv @@
// Log-binned table interpolator. One item transfers per clock: a lookup or a
// node load is taken at any edge with start high and busy low, and busy stays
// low in normal use because every stage advances each cycle. A lookup gives
// its result on velocity, bin_index and range_flag for one cycle with done
// high, in order; the receiver cannot stall, so results must be taken when
// shown. The latency is set by the log2 squaring pipeline (one stage per
// fraction bit) and the 32-stage restoring divider. Loads give no result.
// The node tables are not cleared after reset: load every node that a lookup
// can reach before issuing lookups. Write configuration only when idle.
`default_nettype none
module log_binned_table_interpolator
    import lbti_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 action,
    input  wire logic [T_W-1:0]       t_ratio,
    input  wire logic [IDX_W-1:0]     entry_index,
    input  wire logic [T_W-1:0]       entry_energy,
    input  wire logic [V_W-1:0]       entry_velocity,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output logic                      done,
    output logic [V_W-1:0]            velocity,
    output logic [IDX_W-1:0]          bin_index,
    output logic [1:0]                range_flag
);

    logic [NCNT_W-1:0]  node_count_reg;
    logic [BASE_W-1:0]  log2_min_reg;
    logic [SCALE_W-1:0] bin_scale_reg;
    logic [T_W-1:0]     edge_min_reg;
    logic [T_W-1:0]     edge_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
            log2_min_reg   <= LOG2_MIN_RST;
            bin_scale_reg  <= BIN_SCALE_RST;
            edge_min_reg   <= EDGE_MIN_RST;
            edge_max_reg   <= EDGE_MAX_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NODE_COUNT: node_count_reg <= cfg_data[NCNT_W-1:0];
                CFG_LOG2_MIN:   log2_min_reg   <= cfg_data[BASE_W-1:0];
                CFG_BIN_SCALE:  bin_scale_reg  <= cfg_data[SCALE_W-1:0];
                CFG_EDGE_MIN:   edge_min_reg   <= cfg_data[T_W-1:0];
                CFG_EDGE_MAX:   edge_max_reg   <= cfg_data[T_W-1:0];
                default:        ;
            endcase
        end
    end

    cfg_t cfg;

    // hold the node count to the table
    always_comb
    begin
        if (32'(node_count_reg) > 32'(TABLE_DEPTH))
        begin
            cfg.n = CNT_W'(TABLE_DEPTH);
        end
        else if (node_count_reg < NCNT_W'(2))
        begin
            cfg.n = CNT_W'(2);
        end
        else
        begin
            cfg.n = CNT_W'(node_count_reg);
        end
        cfg.log2_min = log2_min_reg;
        cfg.scale    = bin_scale_reg;
        cfg.edge_min = edge_min_reg;
        cfg.edge_max = edge_max_reg;
    end

    logic   accept;
    logic   push;
    qitem_t push_item;
    logic   pop;
    logic   head_valid;
    qitem_t head;
    logic   full;

    assign busy   = full;
    assign accept = start && !busy;

    lbti_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .action         (action),
        .t_ratio        (t_ratio),
        .entry_index    (entry_index),
        .entry_energy   (entry_energy),
        .entry_velocity (entry_velocity),
        .cfg            (cfg),
        .push           (push),
        .push_item      (push_item)
    );

    lbti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    lbti_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .velocity   (velocity),
        .bin_index  (bin_index),
        .range_flag (range_flag)
    );

endmodule
`default_nettype wire

@@ design/lbti_checker.sv @@
`default_nettype none
`include "log_binned_table_interpolator_defines.svh"
module lbti_checker
    import lbti_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             action,
    input wire logic             done,
    input wire logic [IDX_W-1:0] bin_index,
    input wire logic [1:0]       range_flag
);

    `LBTI_ASSERT_DELAY(a_lookup_gives_result, start && !busy && (action == ACT_LOOKUP), RESULT_LATENCY, done, "accepted lookup gave no result")
    `LBTI_ASSERT_IMPLY(a_result_has_lookup, done, $past(start && !busy && (action == ACT_LOOKUP), RESULT_LATENCY), "result without an accepted lookup")
    `LBTI_ASSERT_IMPLY(a_flag_code, done, (range_flag == RANGE_INSIDE) || (range_flag == RANGE_LOW) || (range_flag == RANGE_HIGH), "range flag out of range")
    `LBTI_ASSERT_IMPLY(a_low_clamp_bin, done && (range_flag == RANGE_LOW), bin_index == '0, "low clamp with nonzero bin")

endmodule

bind log_binned_table_interpolator lbti_checker u_lbti_checker (.*);
`default_nettype wire

@@ verif/velocity_lookup_checker.sv @@
`default_nettype none
module velocity_lookup_checker
    import lbti_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic                 action,
    input  wire logic [T_W-1:0]       t_ratio,
    input  wire logic [IDX_W-1:0]     entry_index,
    input  wire logic [T_W-1:0]       entry_energy,
    input  wire logic [V_W-1:0]       entry_velocity,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 done,
    input  wire logic [V_W-1:0]       velocity,
    input  wire logic [IDX_W-1:0]     bin_index,
    input  wire logic [1:0]           range_flag,
    output int                        fail_count,
    output int                        pending_count,
    output int                        checked_count
);

    typedef struct packed {
        logic [V_W-1:0]   vel;
        logic [IDX_W-1:0] bin;
        range_t           flag;
    } velocity_result_t;

    logic [T_W-1:0]     node_energy [TABLE_DEPTH];
    logic [V_W-1:0]     node_vel    [TABLE_DEPTH];
    logic [NCNT_W-1:0]  node_count;
    logic [BASE_W-1:0]  log2_min;
    logic [SCALE_W-1:0] bin_scale;
    logic [T_W-1:0]     edge_lo;
    logic [T_W-1:0]     edge_hi;

    velocity_result_t expected_velocities[$];

    // log2 of a nonzero Q10.38 value, signed Q.LOG_FRAC_BITS
    function automatic longint log2_q(input logic [T_W-1:0] t);
        int p;
        logic [63:0] m;
        logic [63:0] frac;
        p = T_W - 1;
        while (p > 0 && !t[p])
            p--;
        if (p >= 31)
            m = 64'(t) >> (p - 31);
        else
            m = 64'(t) << (31 - p);
        frac = '0;
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(p - 38) * (longint'(1) << LOG_FRAC_BITS) + longint'(frac);
    endfunction

    function automatic velocity_result_t predict_velocity(input logic [T_W-1:0] t);
        velocity_result_t r;
        int n;
        longint d;
        logic [63:0] ud, hi, lo, b, e0, e1, v0, v1, span, dx, q, rem;
        n = node_count;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (n < 2) n = 2;
        if (t <= edge_lo)
        begin
            r.vel = node_vel[0];
            r.bin = '0;
            r.flag = RANGE_LOW;
        end
        else if (t >= edge_hi)
        begin
            r.vel = node_vel[n-1];
            r.bin = IDX_W'(n - 1);
            r.flag = RANGE_HIGH;
        end
        else
        begin
            d = log2_q(t) - longint'($signed(log2_min));
            b = '0;
            if (d > 0)
            begin
                ud = 64'(d);
                hi = (ud >> 16) * 64'(bin_scale);
                lo = ((ud & 64'hFFFF) * 64'(bin_scale)) >> 16;
                b = (hi + lo) >> (BIN_SHIFT - 16);
            end
            if (b > 64'(n - 2)) b = 64'(n - 2);
            e0 = 64'(node_energy[b]);
            e1 = 64'(node_energy[b+1]);
            v0 = 64'(node_vel[b]);
            v1 = 64'(node_vel[b+1]);
            r.bin = IDX_W'(b);
            r.flag = RANGE_INSIDE;
            if (e1 <= e0)
                r.vel = V_W'(v0);
            else
            begin
                span = e1 - e0;
                dx = (64'(t) > e0) ? 64'(t) - e0 : '0;
                if (dx > span) dx = span;
                // restoring division for floor(dx * 2^31 / span)
                q = '0;
                rem = dx;
                if (rem >= span)
                begin
                    q = 1;
                    rem = rem - span;
                end
                for (int i = 0; i < 31; i++)
                begin
                    rem = rem << 1;
                    q = q << 1;
                    if (rem >= span)
                    begin
                        rem = rem - span;
                        q[0] = 1'b1;
                    end
                end
                if (v1 >= v0)
                    r.vel = V_W'(v0 + (((v1 - v0) * q) >> 31));
                else
                    r.vel = V_W'(v0 - (((v0 - v1) * q) >> 31));
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        velocity_result_t exp_r;
        if (!rst_n)
        begin
            node_count <= NODE_COUNT_RST;
            log2_min   <= LOG2_MIN_RST;
            bin_scale  <= BIN_SCALE_RST;
            edge_lo    <= EDGE_MIN_RST;
            edge_hi    <= EDGE_MAX_RST;
            expected_velocities.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_velocities.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result with nothing expected: vel=%h bin=%0d flag=%0d",
                                 velocity, bin_index, range_flag);
                end
                else
                begin
                    exp_r = expected_velocities.pop_front();
                    checked_count++;
                    if (velocity !== exp_r.vel || bin_index !== exp_r.bin
                        || range_flag !== exp_r.flag)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp vel=%h bin=%0d flag=%0d, ",
                                      "got vel=%h bin=%0d flag=%0d"},
                                     exp_r.vel, exp_r.bin, exp_r.flag,
                                     velocity, bin_index, range_flag);
                    end
                end
            end
            if (start && !busy)
            begin
                if (action == ACT_LOAD)
                begin
                    node_energy[entry_index] = entry_energy;
                    node_vel[entry_index] = entry_velocity;
                end
                else
                    expected_velocities.insert(expected_velocities.size(),
                                               predict_velocity(t_ratio));
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT: node_count <= cfg_data[NCNT_W-1:0];
                    CFG_LOG2_MIN:   log2_min   <= cfg_data[BASE_W-1:0];
                    CFG_BIN_SCALE:  bin_scale  <= cfg_data[SCALE_W-1:0];
                    CFG_EDGE_MIN:   edge_lo    <= cfg_data[T_W-1:0];
                    CFG_EDGE_MAX:   edge_hi    <= cfg_data[T_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_count = expected_velocities.size();
    end

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        checked_count = 0;
    end

endmodule
`default_nettype wire

@@ verif/log_binned_table_interpolator_tb.sv @@
`default_nettype none
module log_binned_table_interpolator_tb;
    import lbti_pkg::*;

    localparam logic [T_W-1:0] T_MAX = '1;
    localparam int FILL_NODES = 160;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 action;
    logic [T_W-1:0]       t_ratio;
    logic [IDX_W-1:0]     entry_index;
    logic [T_W-1:0]       entry_energy;
    logic [V_W-1:0]       entry_velocity;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic [V_W-1:0]       velocity;
    logic [IDX_W-1:0]     bin_index;
    logic [1:0]           range_flag;
    int                   fail_count;
    int                   pending_count;
    int                   checked_count;

    logic [T_W-1:0] energy_plan [TABLE_DEPTH];
    logic [V_W-1:0] vel_plan    [TABLE_DEPTH];
    logic [T_W-1:0] cur_edge_lo;
    logic [T_W-1:0] cur_edge_hi;
    int             burst_left;
    int             lookups_sent;
    int             loads_sent;
    int             settings_used;

    log_binned_table_interpolator dut (.*);

    velocity_lookup_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic logic [T_W-1:0] rand_t();
        return T_W'({$urandom, $urandom});
    endfunction

    // hold start across busy, return at the falling edge after the transfer
    task automatic send_item(input logic act, input logic [T_W-1:0] t,
                             input logic [IDX_W-1:0] idx, input logic [T_W-1:0] e,
                             input logic [V_W-1:0] v);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        start <= 1'b1;
        action <= act;
        t_ratio <= t;
        entry_index <= idx;
        entry_energy <= e;
        entry_velocity <= v;
        while (busy)
            @(negedge clk);
        @(negedge clk);
        burst_left--;
        if (act == ACT_LOAD)
        begin
            energy_plan[idx] = e;
            vel_plan[idx] = v;
            loads_sent++;
        end
        else
            lookups_sent++;
    endtask

    task automatic lookup(input logic [T_W-1:0] t);
        send_item(ACT_LOOKUP, t, IDX_W'($urandom), rand_t(), $urandom);
    endtask

    task automatic load(input int idx, input logic [T_W-1:0] e, input logic [V_W-1:0] v);
        send_item(ACT_LOAD, rand_t(), IDX_W'(idx), e, v);
    endtask

    // lookup somewhere inside bin i of the loaded table
    task automatic lookup_in_bin(input int i);
        logic [T_W-1:0] lo_e, hi_e;
        lo_e = energy_plan[i];
        hi_e = energy_plan[i+1];
        if (hi_e > lo_e)
            lookup(lo_e + T_W'((64'(hi_e - lo_e) * $urandom) >> 32));
        else
            lookup(lo_e + T_W'($urandom_range(0, 3)));
    endtask

    task automatic drain(input int pad);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_count != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (pad) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [NCNT_W-1:0] n, input logic [BASE_W-1:0] lmin,
                                 input logic [SCALE_W-1:0] scale, input logic [T_W-1:0] emin,
                                 input logic [T_W-1:0] emax);
        drain(RESULT_LATENCY + 4);
        write_reg(CFG_NODE_COUNT, CFG_W'(n));
        write_reg(CFG_LOG2_MIN, CFG_W'(lmin));
        write_reg(CFG_BIN_SCALE, CFG_W'(scale));
        write_reg(CFG_EDGE_MIN, CFG_W'(emin));
        write_reg(CFG_EDGE_MAX, CFG_W'(emax));
        cur_edge_lo = emin;
        cur_edge_hi = emax;
        settings_used++;
    endtask

    task automatic random_traffic(input int count);
        int sel;
        int i;
        for (int k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            i = $urandom_range(0, FILL_NODES - 2);
            if (sel < 50)
                lookup_in_bin($urandom_range(0, FILL_NODES - 2));
            else if (sel < 60)
                lookup_in_bin(i);
            else if (sel < 70)
                lookup($urandom_range(0, 1) ? cur_edge_lo + T_W'($urandom_range(0, 2)) - 1
                                            : cur_edge_hi + T_W'($urandom_range(0, 2)) - 1);
            else if (sel < 85)
                lookup(rand_t() >> $urandom_range(0, 47));
            else if (sel < 92)
                load(i, energy_plan[i] + T_W'($urandom_range(0, 255)), $urandom);
            else
                load(i, rand_t(), $urandom);
        end
    endtask

    initial
    begin
        real x;
        logic [V_W-1:0] v;
        int guard;
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOOKUP;
        t_ratio = '0;
        entry_index = '0;
        entry_energy = '0;
        entry_velocity = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        burst_left = 0;
        lookups_sent = 0;
        loads_sent = 0;
        settings_used = 1;
        cur_edge_lo = EDGE_MIN_RST;
        cur_edge_hi = EDGE_MAX_RST;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fill the low nodes, spaced evenly in log2 as the reset binning expects
        v = $urandom_range(0, 1 << 20);
        for (int i = 0; i < FILL_NODES; i++)
        begin
            x = 27487791.0 * (2.0 ** (i / 21.5));
            if (i % 37 == 36)
                v = $urandom;
            else if (i % 11 == 5)
                v = v - $urandom_range(0, 1 << 20);
            else
                v = v + $urandom_range(0, 1 << 22);
            load(i, (x >= 2.0 ** 48) ? T_MAX : T_W'(longint'(x)), v);
        end

        // reset settings: only lookups that stay within the loaded nodes
        lookup('0);
        lookup(EDGE_MIN_RST);
        lookup(EDGE_MIN_RST + 1);
        lookup(energy_plan[100]);
        lookup(energy_plan[101] - 1);
        lookup_in_bin(0);

        // limit the node count to the loaded part of the table
        apply_setting(NCNT_W'(FILL_NODES), LOG2_MIN_RST, BIN_SCALE_RST, EDGE_MIN_RST,
                      EDGE_MAX_RST);

        // directed: edges, exact nodes, degenerate and falling bins
        lookup(T_MAX);
        lookup(EDGE_MAX_RST - 1);
        lookup(EDGE_MAX_RST);
        lookup_in_bin(FILL_NODES - 2);
        load(10, energy_plan[9], 32'hFFFF_FFFF);
        lookup_in_bin(9);
        load(20, energy_plan[19] - 5, 32'h0);
        lookup(energy_plan[19] + 2);
        load(31, energy_plan[31], vel_plan[30] >> 1);
        lookup_in_bin(30);
        lookup(energy_plan[30] - 3);
        load(1023, T_MAX, 32'hFFFF_FFFF);
        load(0, EDGE_MIN_RST, 32'h0000_0001);
        lookup(EDGE_MIN_RST);
        lookup(48'h5555_5555_5555);
        lookup(48'hAAAA_AAAA_AAAA);
        random_traffic(40);

        apply_setting(NCNT_W'(FILL_NODES), LOG2_MIN_RST, BIN_SCALE_RST, EDGE_MIN_RST, T_MAX);
        lookup(T_MAX);
        lookup(T_MAX - 1);
        random_traffic(30);
        apply_setting(11'd102, LOG2_MIN_RST, BIN_SCALE_RST, EDGE_MIN_RST, EDGE_MAX_RST);
        random_traffic(30);
        apply_setting(NCNT_W'(FILL_NODES), 32'h8000_0000, 32'hFFFF_FFFF, '0, T_MAX);
        lookup(48'd1);
        random_traffic(30);
        // node count above the table: every nonzero lookup clamps to the last node
        apply_setting(11'd2047, 32'h8000_0000, 32'hFFFF_FFFF, '0, 48'd1);
        lookup(48'd1);
        random_traffic(15);
        apply_setting(11'd0, 32'h7FFF_FFFF, 32'h0, T_MAX, '0);
        random_traffic(15);
        apply_setting(11'd1, 32'h0, 32'h0100_0000, 48'd2, 48'd3);
        random_traffic(15);
        apply_setting(NCNT_W'($urandom_range(102, FILL_NODES)), $urandom, $urandom,
                      T_W'($urandom), rand_t());
        random_traffic(30);
        apply_setting(NCNT_W'(FILL_NODES), LOG2_MIN_RST, BIN_SCALE_RST, EDGE_MIN_RST,
                      EDGE_MAX_RST);
        random_traffic(30);

        start <= 1'b0;
        guard = 0;
        while (pending_count != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (RESULT_LATENCY + 10) @(negedge clk);

        $display("sent %0d lookups and %0d node loads over %0d register settings",
                 lookups_sent, loads_sent, settings_used);
        $display("checked %0d results, %0d failures, %0d still expected",
                 checked_count, fail_count, pending_count);
        if (fail_count == 0 && pending_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
